// ===== hw/rtl/vertex_point_light_accumulate_assert.svh =====
// Assertion macros shared by the point-light accumulator RTL.
`ifndef VERTEX_POINT_LIGHT_ACCUMULATE_ASSERT_SVH
`define VERTEX_POINT_LIGHT_ACCUMULATE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Plain concurrent check: the property is checked on every rising clock edge out of reset.
`define VPLA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Next-cycle implication: when cond holds, conseq must hold in the cycle after.
`define VPLA_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error(msg);
`else
`define VPLA_ASSERT(label, clk, rst_n, prop, msg)
`define VPLA_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg)
`endif

`endif

// ===== hw/rtl/vpla_pkg.sv =====
// Types and constants of the vertex point-light accumulator.
package vpla_pkg;

	localparam logic KIND_LIGHT  = 1'b0;
	localparam logic KIND_VERTEX = 1'b1;

	// 1.0 in the Q.40 falloff domain and in the Q.52 color sum domain.
	localparam logic [40:0] ONE_Q40 = {1'b1, 40'b0};
	localparam logic [52:0] ONE_Q52 = {1'b1, 52'b0};

	typedef struct packed {
		logic               kind;
		logic [2:0]         slot;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic [15:0]        red;
		logic [15:0]        green;
		logic [15:0]        blue;
		logic [31:0]        inv_radius_sq;
		logic               enable;
	} vpla_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} vpla_out_t;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		logic [15:0]        red;
		logic [15:0]        green;
		logic [15:0]        blue;
		logic [31:0]        falloff;
	} vpla_light_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DX,
		ST_DY,
		ST_DZ,
		ST_T_LO,
		ST_T_HI,
		ST_WGT,
		ST_R_LO,
		ST_R_HI,
		ST_G_LO,
		ST_G_HI,
		ST_B_LO,
		ST_B_HI,
		ST_DONE
	} vpla_state_t;

endpackage

// ===== hw/rtl/vertex_point_light_accumulate.sv =====
// Vertex point-light accumulator: light table, sequencer and shared multiplier.
//
// Input channel (in_valid/in_ready/in_data) carries two kinds of word. A light
// write (kind 0) fills or clears one table slot and gives no result; slots at
// or beyond LIGHT_SLOTS are ignored. A vertex word (kind 1) gives one result
// word on the output channel (out_valid/out_ready/out_data). A vertex visits
// every slot in turn through one 32x32 multiplier and one saturating
// accumulator. An empty slot is only looked up and skipped; a filled slot goes
// through the table read, three squares, two partial products for the falloff,
// the weight, and two partial products per color channel, and the color steps
// are skipped when the light does not reach the vertex. in_ready stays low
// from acceptance of a vertex until its result is loaded into the output
// register; the next word is accepted once the sequencer is back in idle.
// The result sits in an output register, so the next word is accepted while it
// waits; if the receiver still stalls when the following vertex finishes, the
// sequencer holds in its final state until the register frees.
// Reset clears all slot valid bits and the handshake state; slot contents are
// undefined until written and are used only for valid slots.
`include "vertex_point_light_accumulate_assert.svh"

module vertex_point_light_accumulate
	import vpla_pkg::*;
#(
	parameter int LIGHT_SLOTS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  vpla_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output vpla_out_t out_data
);

	localparam int IDX_W = (LIGHT_SLOTS > 1) ? $clog2(LIGHT_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIGHT_SLOTS - 1);

	vpla_state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic [LIGHT_SLOTS-1:0] valid_q;

	vpla_light_t light_mem_q [LIGHT_SLOTS];
	vpla_light_t rd_light_q;

	logic signed [23:0] vx_q, vy_q, vz_q;
	logic [49:0] dsq_q;
	logic [40:0] t_q;
	logic        tov_q;
	logic [40:0] w_q;
	logic [52:0] sum_r_q, sum_g_q, sum_b_q;

	logic      out_valid_q;
	vpla_out_t out_data_q;

	logic              in_acc;
	logic              slot_ok;
	logic [IDX_W-1:0]  wr_idx;
	logic [23:0]       abs_x, abs_y, abs_z;
	logic [31:0]       mul_a, mul_b;
	logic [63:0]       prod;
	logic [56:0]       addend;
	logic [52:0]       acc_sel, acc_new;
	logic [41:0]       tsum;
	logic              out_load;

	function automatic logic [23:0] abs_diff(input logic signed [23:0] a,
			input logic signed [23:0] b);
		logic signed [24:0] d;
		logic [24:0] n;
		d = 25'(a) - 25'(b);
		n = -d;
		return d[24] ? n[23:0] : d[23:0];
	endfunction

	// The sum only grows, so clamping at one each step equals clamping at the end.
	function automatic logic [52:0] sat_add(input logic [52:0] acc, input logic [56:0] add);
		logic [57:0] s;
		s = {5'b0, acc} + {1'b0, add};
		return (s > {5'b0, ONE_Q52}) ? ONE_Q52 : s[52:0];
	endfunction

	// floor(255 * sum / 2^52) for a sum clamped to at most one.
	function automatic logic [7:0] to_byte(input logic [52:0] sum);
		logic [60:0] scaled;
		scaled = {sum, 8'b0} - {8'b0, sum};
		return sum[52] ? 8'hFF : scaled[59:52];
	endfunction

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_ok   = (32'(in_data.slot) < LIGHT_SLOTS);
	assign wr_idx    = IDX_W'(in_data.slot);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign abs_x = abs_diff(rd_light_q.x, vx_q);
	assign abs_y = abs_diff(rd_light_q.y, vy_q);
	assign abs_z = abs_diff(rd_light_q.z, vz_q);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_DX: begin
				mul_a = {8'b0, abs_x};
				mul_b = {8'b0, abs_x};
			end
			ST_DY: begin
				mul_a = {8'b0, abs_y};
				mul_b = {8'b0, abs_y};
			end
			ST_DZ: begin
				mul_a = {8'b0, abs_z};
				mul_b = {8'b0, abs_z};
			end
			ST_T_LO: begin
				mul_a = dsq_q[31:0];
				mul_b = rd_light_q.falloff;
			end
			ST_T_HI: begin
				mul_a = {14'b0, dsq_q[49:32]};
				mul_b = rd_light_q.falloff;
			end
			ST_R_LO: begin
				mul_a = {16'b0, rd_light_q.red};
				mul_b = w_q[31:0];
			end
			ST_R_HI: begin
				mul_a = {16'b0, rd_light_q.red};
				mul_b = {23'b0, w_q[40:32]};
			end
			ST_G_LO: begin
				mul_a = {16'b0, rd_light_q.green};
				mul_b = w_q[31:0];
			end
			ST_G_HI: begin
				mul_a = {16'b0, rd_light_q.green};
				mul_b = {23'b0, w_q[40:32]};
			end
			ST_B_LO: begin
				mul_a = {16'b0, rd_light_q.blue};
				mul_b = w_q[31:0];
			end
			ST_B_HI: begin
				mul_a = {16'b0, rd_light_q.blue};
				mul_b = {23'b0, w_q[40:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign tsum = {1'b0, t_q} + {1'b0, prod[8:0], 32'b0};

	// Shared saturating accumulator: low partial products enter as they are,
	// high partial products are weighted by 2^32.
	always_comb begin
		acc_sel = sum_r_q;
		addend  = {9'b0, prod[47:0]};
		case (state_q)
			ST_R_LO: begin
				acc_sel = sum_r_q;
				addend  = {9'b0, prod[47:0]};
			end
			ST_R_HI: begin
				acc_sel = sum_r_q;
				addend  = {prod[24:0], 32'b0};
			end
			ST_G_LO: begin
				acc_sel = sum_g_q;
				addend  = {9'b0, prod[47:0]};
			end
			ST_G_HI: begin
				acc_sel = sum_g_q;
				addend  = {prod[24:0], 32'b0};
			end
			ST_B_LO: begin
				acc_sel = sum_b_q;
				addend  = {9'b0, prod[47:0]};
			end
			ST_B_HI: begin
				acc_sel = sum_b_q;
				addend  = {prod[24:0], 32'b0};
			end
			default: begin
				acc_sel = sum_r_q;
				addend  = {9'b0, prod[47:0]};
			end
		endcase
	end

	assign acc_new = sat_add(acc_sel, addend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_data.kind == KIND_VERTEX) begin
					state_d = ST_FETCH;
					idx_d   = '0;
				end
			end
			ST_FETCH: begin
				if (valid_q[idx_q]) begin
					state_d = ST_DX;
				end else if (idx_q == LAST_IDX) begin
					state_d = ST_DONE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_DX:   state_d = ST_DY;
			ST_DY:   state_d = ST_DZ;
			ST_DZ:   state_d = ST_T_LO;
			ST_T_LO: state_d = ST_T_HI;
			ST_T_HI: state_d = ST_WGT;
			ST_WGT: begin
				if (!tov_q) begin
					state_d = ST_R_LO;
				end else if (idx_q == LAST_IDX) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FETCH;
					idx_d   = idx_q + 1'b1;
				end
			end
			ST_R_LO: state_d = ST_R_HI;
			ST_R_HI: state_d = ST_G_LO;
			ST_G_LO: state_d = ST_G_HI;
			ST_G_HI: state_d = ST_B_LO;
			ST_B_LO: state_d = ST_B_HI;
			ST_B_HI: begin
				if (idx_q == LAST_IDX) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_FETCH;
					idx_d   = idx_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				idx_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (in_acc && in_data.kind == KIND_LIGHT && slot_ok) begin
			valid_q[wr_idx] <= in_data.enable;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.kind == KIND_LIGHT && slot_ok && in_data.enable) begin
			light_mem_q[wr_idx] <= '{
				x:       in_data.pos_x,
				y:       in_data.pos_y,
				z:       in_data.pos_z,
				red:     in_data.red,
				green:   in_data.green,
				blue:    in_data.blue,
				falloff: in_data.inv_radius_sq
			};
		end
	end

	// The table is read at the slot counter every cycle; the counter holds
	// while a slot is worked on, so the read word stays put.
	always_ff @(posedge clk) begin
		rd_light_q <= light_mem_q[idx_q];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc && in_data.kind == KIND_VERTEX) begin
					vx_q <= in_data.pos_x;
					vy_q <= in_data.pos_y;
					vz_q <= in_data.pos_z;
				end
			end
			ST_DX: dsq_q <= {2'b0, prod[47:0]};
			ST_DY: dsq_q <= dsq_q + {2'b0, prod[47:0]};
			ST_DZ: dsq_q <= dsq_q + {2'b0, prod[47:0]};
			ST_T_LO: begin
				t_q   <= prod[40:0];
				tov_q <= |prod[63:41];
			end
			ST_T_HI: begin
				t_q   <= tsum[40:0];
				tov_q <= tov_q || (|prod[63:9]) || (tsum > {1'b0, ONE_Q40});
			end
			ST_WGT: w_q <= ONE_Q40 - t_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && in_data.kind == KIND_VERTEX) begin
						sum_r_q <= '0;
						sum_g_q <= '0;
						sum_b_q <= '0;
					end
				end
				ST_R_LO, ST_R_HI: sum_r_q <= acc_new;
				ST_G_LO, ST_G_HI: sum_g_q <= acc_new;
				ST_B_LO, ST_B_HI: sum_b_q <= acc_new;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= '{
				red_out:   to_byte(sum_r_q),
				green_out: to_byte(sum_g_q),
				blue_out:  to_byte(sum_b_q)
			};
		end
	end

	`VPLA_ASSERT_NEXT(a_vertex_starts_at_slot0, clk, arst_n,
		in_acc && in_data.kind == KIND_VERTEX,
		state_q == ST_FETCH && idx_q == '0,
		"vertex did not start the slot sweep at slot zero")

	`VPLA_ASSERT_NEXT(a_done_holds_on_stall, clk, arst_n,
		state_q == ST_DONE && out_valid_q && !out_ready,
		state_q == ST_DONE,
		"result overwrote a stalled output word")

	`VPLA_ASSERT_NEXT(a_far_light_skipped, clk, arst_n,
		state_q == ST_WGT && tov_q,
		state_q == ST_FETCH || state_q == ST_DONE,
		"light beyond its radius was accumulated")

	`VPLA_ASSERT(a_sums_saturated, clk, arst_n,
		sum_r_q <= ONE_Q52 && sum_g_q <= ONE_Q52 && sum_b_q <= ONE_Q52,
		"channel sum exceeded one")

endmodule
